// ===== src/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, constants and the CRC-16/CCITT byte update used by the
// descriptor tag stamper.
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned LOC_W  = 32;
	localparam int unsigned HALF_W = 64;

	localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
	localparam logic [CRC_W-1:0]  CRC_SEED    = 16'h0000;
	localparam logic [BYTE_W-1:0] TAG_VERSION = 8'h02;
	localparam logic [BYTE_W-1:0] TAG_SERIAL  = 8'h01;
	localparam logic [BYTE_W-1:0] TAG_ZERO    = 8'h00;

	typedef struct packed {
		logic [CRC_W-1:0] crc;
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  tag_id;
		logic [LOC_W-1:0] location;
	} desc_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== src/dts_if.sv =====
// ----------------------------------------------------------------------------
// dts_if
// Valid/ready channel interfaces for body bytes in and finished tags out.
// ----------------------------------------------------------------------------
interface dts_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  body_byte;
	logic        last;
	logic [15:0] tag_id;
	logic [31:0] location;

	modport source (output valid, output body_byte, output last, output tag_id,
		output location, input ready);
	modport sink (input valid, input body_byte, input last, input tag_id,
		input location, output ready);
endinterface

interface dts_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] tag_low;
	logic [63:0] tag_high;
	logic [15:0] body_crc;
	logic [15:0] body_length;
	logic [7:0]  tag_checksum;

	modport source (output valid, output tag_low, output tag_high, output body_crc,
		output body_length, output tag_checksum, input ready);
	modport sink (input valid, input tag_low, input tag_high, input body_crc,
		input body_length, input tag_checksum, output ready);
endinterface

// ===== src/dts_crc_acc.sv =====
// ----------------------------------------------------------------------------
// dts_crc_acc
// Input register, running CRC and byte count; hands a descriptor summary to
// the tag builder on each last byte.
// ----------------------------------------------------------------------------
module dts_crc_acc (
	input  logic           clk,
	input  logic           arst_n,
	dts_in_if.sink         in,
	output logic           desc_valid,
	output dts_pkg::desc_t desc,
	input  logic           desc_ready
);
	import dts_pkg::*;

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic [ID_W-1:0]   id_s1;
	logic [LOC_W-1:0]  loc_s1;
	logic [CRC_W-1:0]  crc_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              vld_s2;
	desc_t             desc_s2;
	logic [CRC_W-1:0]  crc_next;
	logic [LEN_W-1:0]  cnt_next;
	logic              s2_free;
	logic              adv_s1;

	assign crc_next = crc_byte(crc_q, byte_s1);
	assign cnt_next = cnt_q + LEN_W'(1);
	assign s2_free  = !vld_s2 || desc_ready;
	assign adv_s1   = vld_s1 && (!last_s1 || s2_free);
	assign in.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in.ready) begin
			vld_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			byte_s1 <= in.body_byte;
			last_s1 <= in.last;
			id_s1   <= in.tag_id;
			loc_s1  <= in.location;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_SEED;
			cnt_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				crc_q <= CRC_SEED;
				cnt_q <= '0;
			end else begin
				crc_q <= crc_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && adv_s1 && last_s1) begin
			desc_s2.crc      <= crc_next;
			desc_s2.len      <= cnt_next;
			desc_s2.tag_id   <= id_s1;
			desc_s2.location <= loc_s1;
		end
	end

	assign desc_valid = vld_s2;
	assign desc       = desc_s2;

endmodule

// ===== src/dts_tag_build.sv =====
// ----------------------------------------------------------------------------
// dts_tag_build
// Assembles the 16-byte tag with its checksum and holds it in the output
// register until the transaction completes.
// ----------------------------------------------------------------------------
module dts_tag_build (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           desc_valid,
	input  dts_pkg::desc_t desc,
	output logic           desc_ready,
	dts_out_if.source      out
);
	import dts_pkg::*;

	logic              vld_q;
	logic [HALF_W-1:0] low_q;
	logic [HALF_W-1:0] high_q;
	logic [CRC_W-1:0]  crc_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] sum;

	assign sum = desc.tag_id[7:0] + desc.tag_id[15:8] + TAG_VERSION + TAG_SERIAL
		+ desc.crc[7:0] + desc.crc[15:8] + desc.len[7:0] + desc.len[15:8]
		+ desc.location[7:0] + desc.location[15:8] + desc.location[23:16]
		+ desc.location[31:24];

	assign desc_ready = !vld_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (desc_ready) begin
			vld_q <= desc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			low_q  <= {TAG_ZERO, TAG_SERIAL, TAG_ZERO, sum, TAG_ZERO, TAG_VERSION,
				desc.tag_id};
			high_q <= {desc.location, desc.len, desc.crc};
			crc_q  <= desc.crc;
			len_q  <= desc.len;
			sum_q  <= sum;
		end
	end

	assign out.valid        = vld_q;
	assign out.tag_low      = low_q;
	assign out.tag_high     = high_q;
	assign out.body_crc     = crc_q;
	assign out.body_length  = len_q;
	assign out.tag_checksum = sum_q;

endmodule

// ===== src/descriptor_tag_stamper_top.sv =====
// ----------------------------------------------------------------------------
// descriptor_tag_stamper_top
// Streams descriptor body bytes through a CRC-16/CCITT and byte count and
// emits the finished descriptor tag on each last byte.
//
//   Channel  Direction  Contents
//   in       sink       body_byte, last, tag_id, location
//   out      source     tag_low, tag_high, body_crc, body_length, tag_checksum
//
// One body byte is accepted per cycle unless a stall on out has backed up
// into in; the CRC step of the accumulator is applied once per accepted byte.
// A tag passes the input, descriptor and output registers on its way to out.
// Reset clears the CRC, the count and all valid flags.
// A stall on out holds the tag and backs up into in only once the
// registers behind it are full.
// ----------------------------------------------------------------------------
module descriptor_tag_stamper_top (
	input  logic      clk,
	input  logic      arst_n,
	dts_in_if.sink    in,
	dts_out_if.source out
);
	import dts_pkg::*;

	logic  desc_valid;
	logic  desc_ready;
	desc_t desc;

	dts_crc_acc u_crc_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_ready (desc_ready)
	);

	dts_tag_build u_tag_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_ready (desc_ready),
		.out        (out)
	);

endmodule

// ===== sim/descriptor_tag_stamper_checker.sv =====
// ----------------------------------------------------------------------------
// descriptor_tag_stamper_checker
// Watches the body byte and tag channels of the descriptor tag stamper. It
// keeps its own CRC-16/CCITT and byte count over accepted body bytes, builds
// the expected tag on each last byte, and compares every accepted tag field by
// field against the oldest expected one. It reports the number of failures
// and the number of tags still outstanding.
// ----------------------------------------------------------------------------
module descriptor_tag_stamper_checker (
	input  logic clk,
	input  logic arst_n,
	dts_in_if    in_mon,
	dts_out_if   out_mon,
	output int   fail_count,
	output int   pending_count
);

	timeunit 1ns;
	timeprecision 1ps;

	import dts_pkg::*;

	localparam int CHECKSUM_POS = 4;

	typedef struct {
		logic [HALF_W-1:0] tag_low;
		logic [HALF_W-1:0] tag_high;
		logic [CRC_W-1:0]  crc;
		logic [LEN_W-1:0]  length;
		logic [BYTE_W-1:0] checksum;
	} tag_fields_t;

	tag_fields_t      expected_tags[$];
	tag_fields_t      oldest_tag;
	logic [CRC_W-1:0] body_crc_acc;
	logic [LEN_W-1:0] body_len_acc;

	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] octet);
		logic [CRC_W-1:0] r;
		logic             feedback;
		r = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			feedback = r[CRC_W-1] ^ octet[i];
			r = r << 1;
			if (feedback) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic tag_fields_t stamp_tag(input logic [CRC_W-1:0] crc,
		input logic [LEN_W-1:0] len, input logic [ID_W-1:0] id,
		input logic [LOC_W-1:0] loc);
		logic [BYTE_W-1:0] octet[16];
		logic [BYTE_W-1:0] sum;
		tag_fields_t       r;
		octet[0]  = id[7:0];
		octet[1]  = id[15:8];
		octet[2]  = TAG_VERSION;
		octet[3]  = TAG_ZERO;
		octet[4]  = TAG_ZERO;
		octet[5]  = TAG_ZERO;
		octet[6]  = TAG_SERIAL;
		octet[7]  = TAG_ZERO;
		octet[8]  = crc[7:0];
		octet[9]  = crc[15:8];
		octet[10] = len[7:0];
		octet[11] = len[15:8];
		octet[12] = loc[7:0];
		octet[13] = loc[15:8];
		octet[14] = loc[23:16];
		octet[15] = loc[31:24];
		sum = TAG_ZERO;
		for (int i = 0; i < 16; i++) begin
			if (i != CHECKSUM_POS) begin
				sum = sum + octet[i];
			end
		end
		octet[CHECKSUM_POS] = sum;
		for (int i = 0; i < 8; i++) begin
			r.tag_low[8*i +: 8]  = octet[i];
			r.tag_high[8*i +: 8] = octet[i+8];
		end
		r.crc      = crc;
		r.length   = len;
		r.checksum = sum;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, got %h", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_crc_acc = CRC_SEED;
			body_len_acc = '0;
			expected_tags.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_tags.size() == 0) begin
					$error("tag transaction with no expected tag: tag_low %h, tag_high %h",
						out_mon.tag_low, out_mon.tag_high);
					fail_count++;
				end else begin
					oldest_tag = expected_tags.pop_front();
					check_field("tag_low", oldest_tag.tag_low, out_mon.tag_low);
					check_field("tag_high", oldest_tag.tag_high, out_mon.tag_high);
					check_field("body_crc", 64'(oldest_tag.crc), 64'(out_mon.body_crc));
					check_field("body_length", 64'(oldest_tag.length),
						64'(out_mon.body_length));
					check_field("tag_checksum", 64'(oldest_tag.checksum),
						64'(out_mon.tag_checksum));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				body_crc_acc = crc_fold(body_crc_acc, in_mon.body_byte);
				body_len_acc = body_len_acc + 1'b1;
				if (in_mon.last) begin
					expected_tags.push_back(stamp_tag(body_crc_acc, body_len_acc,
						in_mon.tag_id, in_mon.location));
					body_crc_acc = CRC_SEED;
					body_len_acc = '0;
				end
			end
			pending_count = expected_tags.size();
		end
	end

endmodule

// ===== sim/descriptor_tag_stamper_top_tb.sv =====
// ----------------------------------------------------------------------------
// descriptor_tag_stamper_top_tb
// Drives descriptor bodies into the tag stamper: a short directed set of
// extreme bytes, identifiers and locations, random descriptors under three
// idle patterns, and a long receiver stall. A checker beside the block
// predicts and compares every tag.
// ----------------------------------------------------------------------------
module descriptor_tag_stamper_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_FILL  = -1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   bytes_accepted;
	int   cycle_count;
	int   hold_left;
	bit   hold_done;

	dts_in_if  body_ch();
	dts_out_if tag_ch();

	descriptor_tag_stamper_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (body_ch),
		.out    (tag_ch)
	);

	descriptor_tag_stamper_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (body_ch),
		.out_mon       (tag_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_accepted <= 0;
		end else if (body_ch.valid && body_ch.ready) begin
			bytes_accepted <= bytes_accepted + 1;
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// The receiver stalls once for a long stretch early in the random traffic.
	initial begin
		tag_ch.ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				tag_ch.ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && bytes_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				tag_ch.ready <= 1'b0;
			end else begin
				tag_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] octet, input logic is_last,
		input logic [15:0] id, input logic [31:0] loc);
		while ($urandom_range(99) < send_idle_pct) begin
			body_ch.valid <= 1'b0;
			@(negedge clk);
		end
		body_ch.valid     <= 1'b1;
		body_ch.body_byte <= octet;
		body_ch.last      <= is_last;
		body_ch.tag_id    <= id;
		body_ch.location  <= loc;
		do begin
			@(posedge clk);
		end while (!body_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_descriptor(input int body_len, input int fill,
		input logic [15:0] id, input logic [31:0] loc);
		logic [7:0] octet;
		logic       is_last;
		for (int i = 0; i < body_len; i++) begin
			octet = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
			is_last = (i == body_len - 1);
			if (is_last) begin
				send_byte(octet, 1'b1, id, loc);
			end else begin
				send_byte(octet, 1'b0, 16'($urandom_range(16'hFFFF)), $urandom);
			end
		end
	endtask

	task automatic send_random_descriptors(input int byte_goal);
		int sent;
		int body_len;
		sent = 0;
		while (sent < byte_goal) begin
			body_len = ($urandom_range(7) == 0) ? $urandom_range(13, 80)
				: $urandom_range(1, 12);
			send_descriptor(body_len, RANDOM_FILL, 16'($urandom_range(16'hFFFF)),
				$urandom);
			sent += body_len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		body_ch.valid = 1'b0;
		body_ch.body_byte = '0;
		body_ch.last = 1'b0;
		body_ch.tag_id = '0;
		body_ch.location = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 29;
		recv_idle_pct = 55;
		send_descriptor(1, 8'h00, 16'h0000, 32'h0000_0000);
		send_descriptor(1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_descriptor(4, 8'hFF, 16'h0001, 32'h8000_0000);
		send_descriptor(3, 8'h00, 16'h8000, 32'h0000_0001);
		send_descriptor(6, RANDOM_FILL, 16'h0105, 32'h0001_0200);
		send_descriptor(1, 8'h80, 16'h0002, 32'h7FFF_FFFF);
		send_descriptor(1, 8'h01, 16'h7FFF, 32'h0000_0101);
		send_descriptor(2, RANDOM_FILL, 16'hA55A, 32'h5A5A_A5A5);
		send_random_descriptors(240);

		send_idle_pct = 55;
		recv_idle_pct = 29;
		send_random_descriptors(240);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_descriptors(220);
		body_ch.valid <= 1'b0;

		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/dts_pkg.sv
src/dts_if.sv
src/dts_crc_acc.sv
src/dts_tag_build.sv
src/descriptor_tag_stamper_top.sv
sim/descriptor_tag_stamper_checker.sv
sim/descriptor_tag_stamper_top_tb.sv
